// ----- rtl/core/bts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0]  BPS_RESET = 4'd1;
    localparam logic [15:0] SPR_RESET = 16'd1000;

    typedef enum logic [1:0] {
        REG_BPS  = 2'd0,
        REG_MSB  = 2'd1,
        REG_SKIP = 2'd2,
        REG_SPR  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]  sym_width;
        logic        msb_first_input;
        logic [9:0]  skip_count;
        logic [15:0] symbols_per_record;
    } cfg_t;

    // one byte's worth of slicing work
    typedef struct packed {
        logic [14:0] acc;
        logic [3:0]  nbits;
        logic [3:0]  width;
        logic [3:0]  count;
        logic        ended;
    } work_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = v[7 - k];
        end
        return r;
    endfunction

    // symbols that fit in n bits at width b, capped at 8
    function automatic logic [3:0] sym_quotient(input logic [3:0] n, input logic [3:0] b);
        logic [3:0] q;
        logic [7:0] prod;
        q = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            prod = 8'(k) * {4'd0, b};
            if (prod <= {4'd0, n})
            begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bts_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bts_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bts_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bts_pkg::DATA_W-1:0]  pwdata,
    output logic      [bts_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output bts_pkg::cfg_t                    cfg,
    output logic                             bps_wr
);
    import bts_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign bps_wr = wr_en && (idx == REG_BPS);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_BPS:  cfg_next.sym_width          = pwdata[3:0];
                REG_MSB:  cfg_next.msb_first_input    = pwdata[0];
                REG_SKIP: cfg_next.skip_count         = pwdata[9:0];
                REG_SPR:  cfg_next.symbols_per_record = pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BPS:  prdata = {28'd0, cfg_reg.sym_width};
            REG_MSB:  prdata = {31'd0, cfg_reg.msb_first_input};
            REG_SKIP: prdata = {22'd0, cfg_reg.skip_count};
            REG_SPR:  prdata = {16'd0, cfg_reg.symbols_per_record};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sym_width          <= BPS_RESET;
            cfg_reg.msb_first_input    <= 1'b0;
            cfg_reg.skip_count         <= 10'd0;
            cfg_reg.symbols_per_record <= SPR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bts_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bts_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bts_pkg::cfg_t cfg,
    input  wire logic          bps_wr,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    output logic               entry_wr,
    output bts_pkg::work_t     entry
);
    import bts_pkg::*;

    logic [6:0]  leftover_bits_reg,  leftover_bits_next;
    logic [2:0]  leftover_count_reg, leftover_count_next;
    logic [9:0]  skipped_reg,        skipped_next;
    logic [15:0] symbols_done_reg,   symbols_done_next;
    logic        drop_spare_reg,     drop_spare_next;

    logic [3:0]  width;
    logic [15:0] limit;
    logic [7:0]  ordered;
    logic [3:0]  nbits;
    logic [14:0] acc;
    logic [3:0]  quot;
    logic [7:0]  hit;
    logic [3:0]  first;
    logic        ended;
    logic [3:0]  cnt;
    logic [7:0]  used;
    logic [3:0]  n_left;
    logic [7:0]  keep_mask;
    logic        skipping;
    logic        dropping;
    logic [15:0] sum;

    always_comb
    begin
        if (cfg.sym_width == 4'd0)
        begin
            width = 4'd1;
        end
        else if (cfg.sym_width > 4'd8)
        begin
            width = 4'd8;
        end
        else
        begin
            width = cfg.sym_width;
        end
        limit = (cfg.symbols_per_record == 16'd0) ? 16'd1 : cfg.symbols_per_record;
    end

    assign ordered = cfg.msb_first_input ? data_byte : reverse8(data_byte);
    assign nbits   = {1'b0, leftover_count_reg} + 4'd8;
    assign acc     = {leftover_bits_reg, ordered};
    assign quot    = sym_quotient(nbits, width);

    // record end lands on the first symbol whose running count reaches the limit
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sum    = symbols_done_reg + 16'(i + 1);
            hit[i] = (sum >= limit) && (4'(i + 1) <= quot);
        end
        first = 4'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first = 4'(i + 1);
            end
        end
    end

    assign ended     = |hit;
    assign cnt       = ended ? first : quot;
    assign used      = {4'd0, cnt} * {4'd0, width};
    assign n_left    = nbits - used[3:0];
    assign keep_mask = (8'd1 << n_left[2:0]) - 8'd1;
    assign skipping  = skipped_reg < cfg.skip_count;
    assign dropping  = drop_spare_reg || skipping;

    assign entry_wr    = accept && !dropping;
    assign entry.acc   = acc;
    assign entry.nbits = nbits;
    assign entry.width = width;
    assign entry.count = cnt;
    assign entry.ended = ended;

    always_comb
    begin
        leftover_bits_next  = leftover_bits_reg;
        leftover_count_next = leftover_count_reg;
        skipped_next        = skipped_reg;
        symbols_done_next   = symbols_done_reg;
        drop_spare_next     = drop_spare_reg;
        if (accept)
        begin
            priority if (drop_spare_reg)
            begin
                drop_spare_next = 1'b0;
            end
            else if (skipping)
            begin
                skipped_next = skipped_reg + 10'd1;
            end
            else if (ended)
            begin
                drop_spare_next     = (n_left == 4'd0);
                leftover_bits_next  = 7'd0;
                leftover_count_next = 3'd0;
                symbols_done_next   = 16'd0;
                skipped_next        = 10'd0;
            end
            else
            begin
                leftover_count_next = n_left[2:0];
                leftover_bits_next  = acc[6:0] & keep_mask[6:0];
                symbols_done_next   = symbols_done_reg + {12'd0, cnt};
            end
        end
        if (bps_wr)
        begin
            leftover_bits_next  = 7'd0;
            leftover_count_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= 7'd0;
            leftover_count_reg <= 3'd0;
            skipped_reg        <= 10'd0;
            symbols_done_reg   <= 16'd0;
            drop_spare_reg     <= 1'b0;
        end
        else
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
            skipped_reg        <= skipped_next;
            symbols_done_reg   <= symbols_done_next;
            drop_spare_reg     <= drop_spare_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_spare_clean: assert property (@(posedge clk) disable iff (!rst_n)
        drop_spare_reg |-> (leftover_count_reg == 3'd0) && (symbols_done_reg == 16'd0))
        else $error("spare byte pending with live record state");

    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        entry_wr |-> (entry.count != 4'd0) && (entry.count <= 4'd8)
                     && (used[3:0] <= nbits))
        else $error("bad symbol count for byte");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bts_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bts_queue #(
    parameter int DEPTH = bts_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire bts_pkg::work_t wdata,
    input  wire logic           rd,
    output bts_pkg::work_t      rdata,
    output logic                full,
    output logic                empty
);
    import bts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    work_t             mem [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> !full)
        else $error("work item written into full queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bts_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bts_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bts_pkg::work_t head,
    input  wire logic           head_valid,
    output logic                head_rd,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          symbol,
    output logic                last_of_run,
    output logic                record_end
);
    import bts_pkg::*;

    logic [3:0]  idx_reg,  idx_next;
    logic [3:0]  pos_reg,  pos_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  symbol_reg;
    logic        last_reg;
    logic        rend_reg;

    logic        advance;
    logic [3:0]  pos_cur;
    logic [14:0] shifted;
    logic [8:0]  sym_mask;
    logic        is_last;

    assign advance  = head_valid && (!out_valid_reg || pop);
    assign pos_cur  = (idx_reg == 4'd0) ? head.nbits : pos_reg;
    assign pos_next = pos_cur - head.width;
    assign shifted  = head.acc >> pos_next;
    assign sym_mask = (9'd1 << head.width) - 9'd1;
    assign is_last  = (idx_reg + 4'd1) == head.count;
    assign head_rd  = advance && is_last;
    assign idx_next = is_last ? 4'd0 : idx_reg + 4'd1;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            symbol_reg <= shifted[7:0] & sym_mask[7:0];
            last_reg   <= is_last;
            rend_reg   <= is_last && head.ended;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            pos_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                idx_reg <= idx_next;
                pos_reg <= pos_next;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign symbol      = symbol_reg;
    assign last_of_run = last_reg;
    assign record_end  = rend_reg;

`ifndef NO_ASSERTIONS
    a_idx_in_item: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.count)
        else $error("symbol index past end of item");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/byte_to_symbol_slicer.sv -----
// Byte-to-symbol slicer: an 8-to-N bit gearbox. Bytes go in through a queue-style port
// (push/full) and symbols of 1 to 8 bits come out through another (empty/pop), one
// symbol per item. The front end takes one byte per cycle whenever the internal work
// queue (DEPTH entries) has room; skip and spare bytes are absorbed there and produce
// nothing. The back end emits one symbol per cycle while pop keeps taking them, from a
// registered output stage, so a byte that yields k symbols (up to 8 at 1-bit width)
// holds the back end until all k have been emitted. Configuration is
// through an APB port, registers at 0x0 (width), 0x4 (MSB-first), 0x8 (skip bytes),
// 0xC (symbols per record); write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module byte_to_symbol_slicer #(
    parameter int DEPTH = bts_pkg::QUEUE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bts_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bts_pkg::DATA_W-1:0]  pwdata,
    output logic      [bts_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [7:0]                  data_byte,
    output logic                             empty,
    input  wire logic                        pop,
    output logic      [7:0]                  symbol,
    output logic                             last_of_run,
    output logic                             record_end
);
    import bts_pkg::*;

    cfg_t  cfg;
    logic  bps_wr;
    logic  accept;
    logic  entry_wr;
    work_t entry;
    work_t head;
    logic  q_empty;
    logic  head_rd;

    assign accept = push && !full;

    bts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .bps_wr  (bps_wr)
    );

    bts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .bps_wr    (bps_wr),
        .accept    (accept),
        .data_byte (data_byte),
        .entry_wr  (entry_wr),
        .entry     (entry)
    );

    bts_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (entry_wr),
        .wdata (entry),
        .rd    (head_rd),
        .rdata (head),
        .full  (full),
        .empty (q_empty)
    );

    bts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (!q_empty),
        .head_rd     (head_rd),
        .pop         (pop),
        .empty       (empty),
        .symbol      (symbol),
        .last_of_run (last_of_run),
        .record_end  (record_end)
    );

endmodule

`default_nettype wire
